@@ rtl/rnv_pkg.sv @@
// shared constants and types for the rank block
// no dependencies; compiled before every other file
package rnv_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int VALUE_W   = 32;
   localparam int ADDR_W    = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int RANK_W    = 6;

   // loader to ranker: closed set and its size
   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] count;
   } rnv_start_type;

   // ranker to memory read port
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } rnv_rd_type;

   // loader to memory write port
   typedef struct packed {
      logic               en;
      logic [ADDR_W-1:0]  addr;
      logic [VALUE_W-1:0] data;
   } rnv_wr_type;

endpackage

@@ rtl/rnv_if.sv @@
// valid/ready channel interfaces for input values and output ranks
// depends on rnv_pkg
interface rnv_req_if
   import rnv_pkg::*;
   ;
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic                      is_last;

   modport source (output valid, output value, output is_last, input ready);
   modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface rnv_rsp_if
   import rnv_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [RANK_W-1:0] rank;
   logic              last_rank;

   modport source (output valid, output rank, output last_rank, input ready);
   modport sink   (input valid, input rank, input last_rank, output ready);
endinterface

@@ rtl/rnv_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module rnv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port; data registered on rd_en, valid in the next cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

@@ rtl/rnv_loader.sv @@
// input side: accepts values, writes them to the store, closes the set
// depends on rnv_pkg and rnv_if
module rnv_loader
   import rnv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   rnv_req_if.sink       req_chan,
   input  logic          rank_done,
   output rnv_wr_type    wr,
   output rnv_start_type start
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             accept;
   logic             full;

   assign full           = (count_ff == CNT_W'(MAX_ITEMS));
   assign req_chan.ready = !busy_ff;
   assign accept         = req_chan.valid && !busy_ff;

   // store write; dropped once the store is full
   assign wr.en   = accept && !full;
   assign wr.addr = count_ff[ADDR_W-1:0];
   assign wr.data = req_chan.value;

   // closing transaction starts the rank pass
   assign start.start = accept && req_chan.is_last;
   assign start.count = full ? count_ff : count_ff + CNT_W'(1);

   // element count and busy flag
   always_comb begin
      count_in = count_ff;
      busy_in  = busy_ff;
      if (accept) begin
         if (req_chan.is_last) begin
            count_in = '0;
            busy_in  = 1'b1;
         end else if (!full) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      if (rank_done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
      end
   end

endmodule

@@ rtl/rnv_ranker.sv @@
// rank sequencer: reads each element as key, scans the store, counts smaller
// depends on rnv_pkg and rnv_if
module rnv_ranker
   import rnv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  rnv_start_type       start,
   output rnv_rd_type          rd,
   input  logic [VALUE_W-1:0]  rd_data,
   output logic                rank_done,
   rnv_rsp_if.source           rsp_chan
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_KEY_RD = 4'b0010,
      S_SCAN   = 4'b0100,
      S_OUT    = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [ADDR_W-1:0]  i_ff, i_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic               pend_ff, pend_in;
   logic               key_ok_ff, key_ok_in;
   logic signed [VALUE_W-1:0] key_ff, key_in;
   logic [RANK_W-1:0]  cnt_ff, cnt_in;
   logic               out_valid_ff, out_valid_in;
   logic [RANK_W-1:0]  out_rank_ff, out_rank_in;
   logic               out_last_ff, out_last_in;
   logic               is_final;
   logic               out_free;
   logic               smaller;

   assign is_final = (CNT_W'(i_ff) + CNT_W'(1) == n_ff);
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign smaller  = $signed(rd_data) < key_ff;

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.rank      = out_rank_ff;
   assign rsp_chan.last_rank = out_last_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      pend_in      = pend_ff;
      key_ok_in    = key_ok_ff;
      key_in       = key_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_rank_in  = out_rank_ff;
      out_last_in  = out_last_ff;
      rd.en        = 1'b0;
      rd.addr      = i_ff;
      rank_done    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start.start) begin
               n_in     = start.count;
               i_in     = '0;
               state_in = S_KEY_RD;
            end
         end
         S_KEY_RD: begin
            // read the key element
            rd.en     = 1'b1;
            rd.addr   = i_ff;
            j_in      = '0;
            pend_in   = 1'b0;
            key_ok_in = 1'b0;
            cnt_in    = '0;
            state_in  = S_SCAN;
         end
         S_SCAN: begin
            // first cycle latches the key, later cycles compare
            if (!key_ok_ff) begin
               key_in    = rd_data;
               key_ok_in = 1'b1;
            end else if (pend_ff && smaller) begin
               cnt_in = cnt_ff + RANK_W'(1);
            end
            if (j_ff != n_ff) begin
               rd.en   = 1'b1;
               rd.addr = j_ff[ADDR_W-1:0];
               j_in    = j_ff + CNT_W'(1);
               pend_in = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hand the rank to the output register
            if (out_free) begin
               out_valid_in = 1'b1;
               out_rank_in  = cnt_ff;
               out_last_in  = is_final;
               if (is_final) begin
                  rank_done = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  i_in     = i_ff + ADDR_W'(1);
                  state_in = S_KEY_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         key_ok_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
         key_ok_ff    <= key_ok_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      key_ff      <= key_in;
      cnt_ff      <= cnt_in;
      out_rank_ff <= out_rank_in;
      out_last_ff <= out_last_in;
   end

endmodule

@@ rtl/rank_normalize_values.sv @@
// rank block: each value's rank is the count of set values strictly smaller.
// ranks follow the closing transaction one at a time: a key read, a scan over the n
// stored values through the single read port of the value store, then the output register.
// throughput: non-closing values are taken one per cycle; no input during ranks.
// reset clears the element count and control state; the store is not cleared.
// depends on rnv_pkg, rnv_if, rnv_ram, rnv_loader, rnv_ranker
module rank_normalize_values
   import rnv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   rnv_req_if.sink    req_chan,
   rnv_rsp_if.source  rsp_chan
);

   rnv_wr_type         wr;
   rnv_rd_type         rd;
   rnv_start_type      start;
   logic               rank_done;
   logic [VALUE_W-1:0] rd_data;

   // input side and element count
   rnv_loader u_loader (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rank_done (rank_done),
      .wr        (wr),
      .start     (start)
   );

   // value store
   rnv_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr.en),
      .wr_addr    (wr.addr),
      .wr_data    (wr.data),
      .rd_en      (rd.en),
      .rd_addr    (rd.addr),
      .rd_data_ff (rd_data)
   );

   // rank scan and output register
   rnv_ranker u_ranker (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .rd        (rd),
      .rd_data   (rd_data),
      .rank_done (rank_done),
      .rsp_chan  (rsp_chan)
   );

endmodule
